[rtl/grid_line_of_sight_check_top_defines.svh]
// Assertion macros shared by the grid line-of-sight RTL.
// Included by modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef GRID_LINE_OF_SIGHT_CHECK_TOP_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define GLOS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glos: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define GLOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glos: next-cycle check failed");

`endif

[rtl/glos_pkg.sv]
// Shared types and constants for the grid line-of-sight checker.
// No dependencies; used by glos_ctrl, glos_dp and the top level.
`default_nettype none

package glos_pkg;

    // Fixed arithmetic widths
    localparam int COORD_W  = 19;   // signed Q10.8 cell coordinate
    localparam int DIFF_W   = 20;   // coordinate difference
    localparam int D2_W     = 40;   // squared distance
    localparam int ROOT_W   = 20;   // distance, Q.8
    localparam int UNIT_W   = 16;   // signed Q1.14 direction
    localparam int POS_W    = 27;   // signed Q.14 walk position
    localparam int TEST_W   = 9;
    localparam int CNT_W    = 5;

    // Sequencer step counts
    localparam int CONV_LAST = 3;   // four coordinate conversions
    localparam int SQ_LAST   = 2;   // difference, dx^2, dy^2
    localparam int SQRT_LAST = 20;  // init plus twenty root bits
    localparam int DIV_LAST  = 15;  // init plus fifteen quotient bits

    localparam logic signed [UNIT_W-1:0] UNIT_ONE = 16'sd16384;
    localparam logic [TEST_W-1:0]        WALK_CAP = 9'd256;

    // Item kinds (tuser)
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_INV_RES = 2'd0;
    localparam logic [1:0] CFG_SHIFT_X = 2'd1;
    localparam logic [1:0] CFG_SHIFT_Y = 2'd2;
    localparam logic [1:0] CFG_THRESH  = 2'd3;

    // Coordinate conversion select
    localparam logic [1:0] CONV_RX = 2'd0;
    localparam logic [1:0] CONV_RY = 2'd1;
    localparam logic [1:0] CONV_TX = 2'd2;
    localparam logic [1:0] CONV_TY = 2'd3;

    // Squaring phases
    localparam logic [1:0] SQ_DIFF = 2'd0;
    localparam logic [1:0] SQ_XX   = 2'd1;
    localparam logic [1:0] SQ_YY   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       clear_en;
        logic       load_item;
        logic       conv_en;
        logic [1:0] conv_sel;
        logic       sq_en;
        logic [1:0] sq_phase;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_sel;
        logic       div_store;
        logic       walk_init;
        logic       walk_read;
        logic       walk_check;
        logic       out_load;
    } glos_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic dist_zero;
        logic walk_stop;
    } glos_status_t;

endpackage

`default_nettype wire

[rtl/glos_ctrl.sv]
// Sequencer for the grid line-of-sight checker: clearing pass, query steps, output handshake.
// Depends on glos_pkg; drives glos_dp through glos_cmd_t.
`default_nettype none

module glos_ctrl
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire                       s_tuser,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    input  glos_pkg::glos_status_t    status,
    output glos_pkg::glos_cmd_t       cmd
);
    import glos_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CONV  = 4'd2;
    localparam logic [3:0] ST_SQ    = 4'd3;
    localparam logic [3:0] ST_SQRT  = 4'd4;
    localparam logic [3:0] ST_DIVX  = 4'd5;
    localparam logic [3:0] ST_DIVY  = 4'd6;
    localparam logic [3:0] ST_WINIT = 4'd7;
    localparam logic [3:0] ST_WREAD = 4'd8;
    localparam logic [3:0] ST_WCHK  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    cnt_next      = '0;
                    state_next    = (s_tuser == CMD_QUERY) ? ST_CONV : ST_DONE;
                end
            end
            ST_CONV:
            begin
                cmd.conv_en  = 1'b1;
                cmd.conv_sel = cnt_reg[1:0];
                if (cnt_reg == CNT_W'(CONV_LAST))
                begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SQ:
            begin
                cmd.sq_en    = 1'b1;
                cmd.sq_phase = cnt_reg[1:0];
                if (cnt_reg == CNT_W'(SQ_LAST))
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SQRT:
            begin
                cmd.sqrt_init = (cnt_reg == '0);
                cmd.sqrt_step = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(SQRT_LAST))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIVX;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DIVX, ST_DIVY:
            begin
                // zero distance: nothing to walk, result already preset
                if (state_reg == ST_DIVX && cnt_reg == '0 && status.dist_zero)
                    state_next = ST_DONE;
                else
                begin
                    cmd.div_sel   = (state_reg == ST_DIVY);
                    cmd.div_init  = (cnt_reg == '0);
                    cmd.div_step  = (cnt_reg != '0);
                    cmd.div_store = (cnt_reg == CNT_W'(DIV_LAST));
                    if (cnt_reg == CNT_W'(DIV_LAST))
                    begin
                        cnt_next   = '0;
                        state_next = (state_reg == ST_DIVX) ? ST_DIVY : ST_WINIT;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WINIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = ST_WREAD;
            end
            ST_WREAD:
            begin
                cmd.walk_read = 1'b1;
                state_next    = ST_WCHK;
            end
            ST_WCHK:
            begin
                cmd.walk_check = 1'b1;
                state_next     = status.walk_stop ? ST_DONE : ST_WREAD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/glos_dp.sv]
// Datapath of the grid line-of-sight checker: config registers, grid memory,
// coordinate scaling, distance root, direction divide and the walk. Depends on glos_pkg.
`default_nettype none
`include "grid_line_of_sight_check_top_defines.svh"

module glos_dp
#(
    parameter int MAP_DIM_X = 128,
    parameter int MAP_DIM_Y = 128
)
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  glos_pkg::glos_cmd_t       cmd,
    output glos_pkg::glos_status_t    status,
    input  wire                       cfg_valid,
    input  wire  [1:0]                cfg_index,
    input  wire  [15:0]               cfg_data,
    input  wire  [87:0]               s_tdata,
    input  wire                       s_tuser,
    output logic [15:0]               m_tdata
);
    import glos_pkg::*;

    localparam int CELLS = MAP_DIM_X * MAP_DIM_Y;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(MAP_DIM_X);
    localparam int YW    = $clog2(MAP_DIM_Y);
    localparam logic signed [POS_W-1:0] SAT_HI = 27'sd262143;
    localparam logic signed [POS_W-1:0] SAT_LO = -27'sd262144;

    // Item fields
    logic [6:0]         in_cell_x, in_cell_y;
    logic               in_known;
    logic [7:0]         in_value;
    logic signed [15:0] in_rx, in_ry, in_tx, in_ty;

    assign in_cell_x = s_tdata[6:0];
    assign in_cell_y = s_tdata[13:7];
    assign in_known  = s_tdata[14];
    assign in_value  = s_tdata[22:15];
    assign in_rx     = s_tdata[38:23];
    assign in_ry     = s_tdata[54:39];
    assign in_tx     = s_tdata[70:55];
    assign in_ty     = s_tdata[86:71];

    // Configuration registers
    logic [15:0] inv_res_reg;
    logic [6:0]  shift_x_reg, shift_y_reg;
    logic [7:0]  thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_res_reg <= 16'd6554;
            shift_x_reg <= 7'd64;
            shift_y_reg <= 7'd64;
            thresh_reg  <= 8'd128;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_INV_RES: inv_res_reg <= cfg_data;
                CFG_SHIFT_X: shift_x_reg <= cfg_data[6:0];
                CFG_SHIFT_Y: shift_y_reg <= cfg_data[6:0];
                CFG_THRESH:  thresh_reg  <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    // Latched world positions
    logic signed [15:0] rx_reg, ry_reg, tx_reg, ty_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            rx_reg <= in_rx;
            ry_reg <= in_ry;
            tx_reg <= in_tx;
            ty_reg <= in_ty;
        end
    end

    // Coordinate conversion: one multiply, offset and saturate per cycle
    logic signed [15:0]        conv_w;
    logic [6:0]                conv_shift;
    logic signed [32:0]        conv_prod;
    logic signed [POS_W-1:0]   conv_sum;
    logic signed [POS_W-1:0]   shift_term;
    logic signed [COORD_W-1:0] conv_sat;
    logic signed [COORD_W-1:0] coord_reg [4];

    always_comb
    begin
        unique case (cmd.conv_sel)
            CONV_RX: begin conv_w = rx_reg; conv_shift = shift_x_reg; end
            CONV_RY: begin conv_w = ry_reg; conv_shift = shift_y_reg; end
            CONV_TX: begin conv_w = tx_reg; conv_shift = shift_x_reg; end
            default: begin conv_w = ty_reg; conv_shift = shift_y_reg; end
        endcase
        conv_prod  = 33'(conv_w) * $signed({17'b0, inv_res_reg});
        shift_term = $signed({12'b0, conv_shift, 8'b0});
        conv_sum   = POS_W'(conv_prod >>> 8) + shift_term;
        if (conv_sum > SAT_HI)
            conv_sat = SAT_HI[COORD_W-1:0];
        else if (conv_sum < SAT_LO)
            conv_sat = SAT_LO[COORD_W-1:0];
        else
            conv_sat = conv_sum[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.conv_en)
            coord_reg[cmd.conv_sel] <= conv_sat;
    end

    // Differences and squared distance, one multiplier shared
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [DIFF_W-1:0] sq_op;
    logic signed [D2_W-1:0]   sq_prod;
    logic [D2_W-1:0]          d2_reg;

    assign sq_op   = (cmd.sq_phase == SQ_XX) ? dx_reg : dy_reg;
    assign sq_prod = sq_op * sq_op;

    always_ff @(posedge clk)
    begin
        if (cmd.sq_en)
        begin
            unique case (cmd.sq_phase)
                SQ_DIFF:
                begin
                    dx_reg <= DIFF_W'(coord_reg[CONV_TX]) - DIFF_W'(coord_reg[CONV_RX]);
                    dy_reg <= DIFF_W'(coord_reg[CONV_TY]) - DIFF_W'(coord_reg[CONV_RY]);
                end
                SQ_XX:   d2_reg <= $unsigned(sq_prod);
                SQ_YY:   d2_reg <= d2_reg + $unsigned(sq_prod);
                default: ;
            endcase
        end
    end

    // Integer square root, one result bit per cycle
    logic [21:0]       rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [D2_W-1:0]   rad_reg;
    logic [23:0]       rem_sh;
    logic [23:0]       trial;

    assign rem_sh = {rem_reg, rad_reg[D2_W-1 -: 2]};
    assign trial  = {2'b0, root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            rad_reg  <= d2_reg;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[D2_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= 22'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[21:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Direction divide, one quotient bit per cycle, shared by x and y
    logic signed [DIFF_W-1:0] div_src;
    logic [DIFF_W-1:0]        div_mag;
    logic [20:0]              dr_reg;
    logic                     dlsb_reg;
    logic                     dneg_reg;
    logic [14:0]              q_reg;
    logic [21:0]              dr_sh;
    logic                     q_bit;
    logic [14:0]              q_next;
    logic signed [UNIT_W-1:0] q_signed;
    logic signed [UNIT_W-1:0] ux_reg, uy_reg;

    assign div_src  = cmd.div_sel ? dy_reg : dx_reg;
    assign div_mag  = div_src[DIFF_W-1] ? DIFF_W'(-div_src) : div_src;
    assign dr_sh    = {dr_reg, dlsb_reg};
    assign q_bit    = (dr_sh >= {2'b0, root_reg});
    assign q_next   = {q_reg[13:0], q_bit};
    assign q_signed = dneg_reg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            dr_reg   <= {2'b0, div_mag[DIFF_W-1:1]};
            dlsb_reg <= div_mag[0];
            dneg_reg <= div_src[DIFF_W-1];
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            dr_reg   <= q_bit ? 21'(dr_sh - {2'b0, root_reg}) : dr_sh[20:0];
            dlsb_reg <= 1'b0;
            q_reg    <= q_next;
            if (cmd.div_store)
            begin
                if (cmd.div_sel)
                    uy_reg <= q_signed;
                else
                    ux_reg <= q_signed;
            end
        end
    end

    // Walk position and cell address
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic [TEST_W-1:0]       steps_reg;
    logic [TEST_W-1:0]       tested_reg;
    logic                    reach_reg, left_reg;
    logic                    in_map_reg;
    logic [12:0]             cxu, cyu;
    logic                    in_map;
    logic [AW-1:0]           rd_addr;
    logic [12:0]             steps_raw;

    assign cxu       = px_reg[POS_W-1:14];
    assign cyu       = py_reg[POS_W-1:14];
    assign in_map    = !cxu[12] && !cyu[12]
                       && (cxu < 13'(MAP_DIM_X)) && (cyu < 13'(MAP_DIM_Y));
    assign rd_addr   = AW'(cxu[XW-1:0]) * AW'(MAP_DIM_Y) + AW'(cyu[YW-1:0]);
    assign steps_raw = {1'b0, root_reg[ROOT_W-1:8]} + 13'd1;

    // Grid memory: {known, value}; clear pass, cell writes, walk reads
    logic [8:0]    mem [CELLS];
    logic [8:0]    rd_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          wr_in_range;
    logic [AW-1:0] wr_addr;
    logic          blocked;

    assign wr_in_range = (11'(in_cell_x) < 11'(MAP_DIM_X)) && (11'(in_cell_y) < 11'(MAP_DIM_Y));
    assign wr_addr     = AW'(in_cell_x) * AW'(MAP_DIM_Y) + AW'(in_cell_y);
    assign blocked     = rd_reg[8] && (rd_reg[7:0] < thresh_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
            mem[clr_cnt_reg] <= '0;
        else if (cmd.load_item && s_tuser == CMD_WRITE && wr_in_range)
            mem[wr_addr] <= {in_known, in_value};
        if (cmd.walk_read)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clear_en && !status.clear_last)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // Walk bookkeeping and result
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            reach_reg  <= 1'b1;
            left_reg   <= 1'b0;
            tested_reg <= '0;
        end
        if (cmd.walk_init)
        begin
            px_reg    <= POS_W'(coord_reg[CONV_RX]) <<< 6;
            py_reg    <= POS_W'(coord_reg[CONV_RY]) <<< 6;
            steps_reg <= (steps_raw > 13'(WALK_CAP)) ? WALK_CAP : steps_raw[TEST_W-1:0];
        end
        if (cmd.walk_read)
        begin
            in_map_reg <= in_map;
            tested_reg <= tested_reg + 1'b1;
        end
        if (cmd.walk_check)
        begin
            if (!in_map_reg)
                left_reg <= 1'b1;
            else if (blocked)
                reach_reg <= 1'b0;
            else
            begin
                px_reg <= px_reg + POS_W'(ux_reg);
                py_reg <= py_reg + POS_W'(uy_reg);
            end
        end
        if (cmd.out_load)
            m_tdata <= {5'b0, tested_reg, left_reg, reach_reg};
    end

    assign status.clear_last = (clr_cnt_reg == AW'(CELLS - 1));
    assign status.dist_zero  = (root_reg == '0);
    assign status.walk_stop  = !in_map_reg || blocked || (tested_reg == steps_reg);

    `GLOS_ASSERT_IMP(a_walk_count, cmd.walk_check, tested_reg != '0 && tested_reg <= steps_reg)
    `GLOS_ASSERT_IMP(a_unit_range, cmd.walk_init, ux_reg <= UNIT_ONE && ux_reg >= -UNIT_ONE && uy_reg <= UNIT_ONE && uy_reg >= -UNIT_ONE)
    `GLOS_ASSERT_NEXT(a_clear_runs, cmd.clear_en && !status.clear_last, cmd.clear_en)

endmodule

`default_nettype wire

[rtl/grid_line_of_sight_check_top.sv]
// Sequence: a cell write goes from acceptance straight to the output register; a query
// runs the coordinate conversions, the squaring, the root, the x and y divides, walk init
// and then the read-and-check loop on the grid memory for N cells tested (up to 256);
// a zero-distance query skips the divides and the walk. One item is in work at a time.
// Reset: after rst_n rises a clearing pass writes MAP_DIM_X*MAP_DIM_Y grid entries,
// one per cycle, while s_tready stays low; config writes are taken at any time.
`default_nettype none

module grid_line_of_sight_check_top
#(
    parameter int MAP_DIM_X = 128,
    parameter int MAP_DIM_Y = 128
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // cell_x[6:0] cell_y[13:7] cell_known[14] cell_value[22:15] robot_x[38:23]
    // robot_y[54:39] goal_x[70:55] goal_y[86:71], zero pad [87]
    input  wire  [87:0] s_tdata,
    input  wire         s_tuser,   // command
    output logic        m_tvalid,
    input  wire         m_tready,
    // reachable[0] left_map[1] cells_tested[10:2], zero pad [15:11]
    output logic [15:0] m_tdata,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    import glos_pkg::*;

    glos_cmd_t    cmd;
    glos_status_t status;

    assign cfg_ready = 1'b1;

    glos_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    glos_dp
    #(
        .MAP_DIM_X (MAP_DIM_X),
        .MAP_DIM_Y (MAP_DIM_Y)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[tb/grid_line_of_sight_check_top_tb.sv]
// Self-checking testbench for grid_line_of_sight_check_top: cell writes and ray-march queries.
// Uses glos_pkg for command and register codes; an internal predictor supplies expected results.
`default_nettype none

module grid_line_of_sight_check_top_tb;
    import glos_pkg::*;

    localparam int DIM        = 128;
    localparam int CYCLE_CAP  = 3000000;
    localparam int RAND_ITEMS = 1020;
    localparam int NPHASE     = 6;
    localparam int DRAIN      = 700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    grid_line_of_sight_check_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the grid and settings
    logic        occ_known [DIM*DIM];
    logic [7:0]  occ_value [DIM*DIM];
    logic [15:0] cur_inv_res = 16'd6554;
    logic [6:0]  cur_shift_x = 7'd64;
    logic [6:0]  cur_shift_y = 7'd64;
    logic [7:0]  cur_thresh  = 8'd128;

    // Expected results: {cells_tested, left_map, reachable}
    logic [10:0] sight_q[$];

    int cycles = 0;
    int mismatches = 0;
    int results_seen = 0;
    int n_query = 0, n_write = 0, n_left = 0, n_blocked = 0;
    int tx_idle = 0, rx_idle = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // World position to saturated Q10.8 cell coordinate
    function automatic longint world_to_cell(logic signed [15:0] w, logic [6:0] sh);
        longint c;
        c = (longint'(w) * longint'({1'b0, cur_inv_res})) >>> 8;
        c = c + longint'({1'b0, sh}) * 256;
        if (c > 262143)
            c = 262143;
        if (c < -262144)
            c = -262144;
        return c;
    endfunction

    // Apply one item to the predictor grid and return the line-of-sight result
    function automatic logic [10:0] trace_sight(logic cmd, logic [87:0] d);
        logic reach, left;
        int tested;
        longint fx, fy, tx, ty, dx, dy, span, ux, uy, px, py, steps, gx, gy;
        reach = 1'b1;
        left = 1'b0;
        tested = 0;
        if (cmd == CMD_WRITE)
        begin
            occ_known[d[6:0]*DIM + d[13:7]] = d[14];
            occ_value[d[6:0]*DIM + d[13:7]] = d[22:15];
        end
        else
        begin
            fx = world_to_cell(d[38:23], cur_shift_x);
            fy = world_to_cell(d[54:39], cur_shift_y);
            tx = world_to_cell(d[70:55], cur_shift_x);
            ty = world_to_cell(d[86:71], cur_shift_y);
            dx = tx - fx;
            dy = ty - fy;
            span = longint'(int_sqrt(longint'(dx*dx + dy*dy)));
            if (span > 0)
            begin
                ux = (dx * 16384) / span;
                uy = (dy * 16384) / span;
                px = fx * 64;
                py = fy * 64;
                steps = span / 256 + 1;
                if (steps > 256)
                    steps = 256;
                for (longint i = 0; i < steps; i++)
                begin
                    gx = px >>> 14;
                    gy = py >>> 14;
                    tested++;
                    if (gx < 0 || gx >= DIM || gy < 0 || gy >= DIM)
                    begin
                        left = 1'b1;
                        break;
                    end
                    if (occ_known[gx*DIM + gy] && occ_value[gx*DIM + gy] < cur_thresh)
                    begin
                        reach = 1'b0;
                        break;
                    end
                    px += ux;
                    py += uy;
                end
            end
        end
        return {tested[8:0], left, reach};
    endfunction

    // Offer one item and wait for it to be taken; expectation queued at acceptance
    task automatic send_item(logic cmd, logic [87:0] d, bit typed, logic [10:0] typed_res);
        logic [10:0] res;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        @(negedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        res = trace_sight(cmd, d);
        sight_q.push_back(typed ? typed_res : res);
        if (cmd == CMD_QUERY)
        begin
            n_query++;
            if (res[1])
                n_left++;
            if (!res[0])
                n_blocked++;
        end
        else
            n_write++;
        @(posedge clk);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        case (idx)
            CFG_INV_RES: cur_inv_res = val;
            CFG_SHIFT_X: cur_shift_x = val[6:0];
            CFG_SHIFT_Y: cur_shift_y = val[6:0];
            CFG_THRESH:  cur_thresh  = val[7:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sight_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [87:0] pack_write(logic [6:0] x, logic [6:0] y,
                                               logic kn, logic [7:0] v);
        return {65'd0, v, kn, y, x};
    endfunction

    function automatic logic [87:0] pack_query(logic [15:0] rx, logic [15:0] ry,
                                               logic [15:0] tx, logic [15:0] ty);
        return {1'b0, ty, tx, ry, rx, 8'd0, 1'b0, 14'd0};
    endfunction

    // Random world coordinate: mostly around the mapped area, sometimes anywhere
    function automatic logic [15:0] rand_world();
        int hw;
        hw = (64 * 65536) / (int'(cur_inv_res) + 1);
        hw = hw + hw / 4 + 2;
        if (hw > 32767 || $urandom_range(9) == 0)
            return 16'($urandom_range(65535));
        return 16'($urandom_range(2*hw) - hw);
    endfunction

    // Receiver: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 150)
        begin
            hold_done <= 1'b1;
            hold_left <= 2000;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle);
    end

    // Result check, sampled mid-cycle ahead of the accepting edge
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (sight_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                logic [10:0] want;
                want = sight_q.pop_front();
                if (m_tdata[0] !== want[0] || m_tdata[1] !== want[1]
                    || m_tdata[10:2] !== want[10:2])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected reach=%b left=%b tested=%0d,",
                                  " got reach=%b left=%b tested=%0d"},
                                 results_seen, want[0], want[1], want[10:2],
                                 m_tdata[0], m_tdata[1], m_tdata[10:2]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    typedef struct {
        logic        cmd;
        logic [87:0] data;
        bit          typed;
        logic [10:0] res;
    } stim_row_t;

    // Settings per random phase: inverse resolution, shift x, shift y, threshold
    logic [15:0] ph_inv [NPHASE] = '{16'd6554, 16'd65535, 16'd0, 16'd13107, 16'd3000, 16'd9000};
    logic [6:0]  ph_sx  [NPHASE] = '{7'd64, 7'd0, 7'd127, 7'd32, 7'd64, 7'd100};
    logic [6:0]  ph_sy  [NPHASE] = '{7'd64, 7'd127, 7'd0, 7'd96, 7'd64, 7'd20};
    logic [7:0]  ph_th  [NPHASE] = '{8'd128, 8'd255, 8'd0, 8'd200, 8'd64, 8'd1};

    initial
    begin
        stim_row_t rows[$];
        logic [10:0] ok_write;
        logic [87:0] d;
        for (int i = 0; i < DIM*DIM; i++)
        begin
            occ_known[i] = 1'b0;
            occ_value[i] = 8'd0;
        end
        ok_write = {9'd0, 1'b0, 1'b1};

        // Directed part at reset settings
        rows.push_back('{CMD_WRITE, pack_write(7'd0, 7'd0, 1'b1, 8'd255), 1, ok_write});
        rows.push_back('{CMD_WRITE, pack_write(7'd127, 7'd127, 1'b1, 8'd0), 1, ok_write});
        rows.push_back('{CMD_WRITE, pack_write(7'd64, 7'd64, 1'b1, 8'd0), 1, ok_write});
        rows.push_back('{CMD_WRITE, pack_write(7'd70, 7'd64, 1'b0, 8'd0), 1, ok_write});
        rows.push_back('{CMD_WRITE, pack_write(7'd75, 7'd64, 1'b1, 8'd200), 1, ok_write});
        // robot sits on a blocking cell: one cell tested
        rows.push_back('{CMD_QUERY, pack_query(16'd0, 16'd0, 16'd100, 16'd0), 1,
                         {9'd1, 1'b0, 1'b0}});
        // zero distance
        rows.push_back('{CMD_QUERY, pack_query(16'd500, 16'hFE00, 16'd500, 16'hFE00), 1,
                         {9'd0, 1'b0, 1'b1}});
        // saturated coordinates start off the map
        rows.push_back('{CMD_QUERY, pack_query(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF), 1,
                         {9'd1, 1'b1, 1'b1}});
        rows.push_back('{CMD_QUERY, pack_query(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000), 1,
                         {9'd1, 1'b1, 1'b1}});
        rows.push_back('{CMD_WRITE, pack_write(7'd64, 7'd64, 1'b1, 8'd128), 1, ok_write});
        // unknown and high-valued cells pass, walk leaves the map
        rows.push_back('{CMD_QUERY, pack_query(16'd0, 16'd0, 16'd1000, 16'd0), 0, '0});
        rows.push_back('{CMD_QUERY, pack_query(16'd0, 16'd0, 16'hFC18, 16'hFC18), 0, '0});
        rows.push_back('{CMD_QUERY, pack_query(16'd300, 16'hFED4, 16'hFF00, 16'd200), 0, '0});
        rows.push_back('{CMD_WRITE, pack_write(7'd66, 7'd66, 1'b1, 8'd127), 1, ok_write});
        rows.push_back('{CMD_QUERY, pack_query(16'd0, 16'd0, 16'd600, 16'd600), 0, '0});
        rows.push_back('{CMD_QUERY, pack_query(16'd5, 16'd7, 16'd6, 16'd7), 0, '0});
        rows.push_back('{CMD_QUERY, pack_query(16'hFD80, 16'd630, 16'd630, 16'hFD80), 0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle = 23;
        rx_idle = 72;
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].data, rows[i].typed, rows[i].res);

        // Random part in phases, settings changed only while idle
        for (int ph = 0; ph < NPHASE; ph++)
        begin
            wait_idle();
            tx_idle = (ph < 2) ? 23 : (ph < 4) ? 72 : 0;
            rx_idle = (ph < 2) ? 72 : (ph < 4) ? 23 : 0;
            write_reg(CFG_INV_RES, ph_inv[ph]);
            write_reg(CFG_SHIFT_X, {9'd0, ph_sx[ph]});
            write_reg(CFG_SHIFT_Y, {9'd0, ph_sy[ph]});
            write_reg(CFG_THRESH,  {8'd0, ph_th[ph]});
            for (int n = 0; n < RAND_ITEMS / NPHASE; n++)
            begin
                if ($urandom_range(99) < 35)
                    send_item(CMD_WRITE, pack_write(7'($urandom_range(127)),
                              7'($urandom_range(127)), ($urandom_range(3) != 0),
                              8'($urandom_range(255))), 0, '0);
                else if ($urandom_range(19) == 0)
                begin
                    // raw noise, pad bit kept clear
                    d = 88'({$urandom, $urandom, $urandom});
                    send_item(CMD_QUERY, {1'b0, d[86:0]}, 0, '0);
                end
                else
                    send_item(CMD_QUERY, pack_query(rand_world(), rand_world(),
                              rand_world(), rand_world()), 0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (sight_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d cell writes and %0d queries (%0d left the map, %0d blocked)",
                 n_write, n_query, n_left, n_blocked);
        $display("over %0d register settings, %0d mismatches", NPHASE, mismatches);
        if (mismatches == 0 && sight_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
